// ===== design/lipc_pkg.sv =====
// Shared types, constants and reset values for the leaky-integral PID controller.
package lipc_pkg;

  // Fixed-point format and integrator size.
  localparam int FRAC_BITS      = 16;
  localparam int INTEGRAL_WIDTH = 40;

  // Leak factor is unsigned Q1.16 held in 17 bits; 65536 means 1.0.
  localparam int LEAK_BITS = 16;
  localparam int LEAK_W    = LEAK_BITS + 1;
  localparam logic [LEAK_W-1:0] LEAK_ONE = LEAK_W'(1 << LEAK_BITS);

  // Shared multiplier: 33 x 33 signed, so that both signed and unsigned 32-bit operands fit.
  localparam int DATA_W = 32;
  localparam int MUL_W  = DATA_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int TERM_W = PROD_W + DATA_W;

  // Accumulator widths: correction sum and leaked integral.
  localparam int ACC_W  = INTEGRAL_WIDTH + DATA_W + 2 - FRAC_BITS;
  localparam int IACC_W = INTEGRAL_WIDTH + 2;

  // Scaled inputs (raw / 1000), error and one tenth of the scaled setpoint.
  localparam int SCL_W = 23;
  localparam int ERR_W = SCL_W + 1;
  localparam int TEN_W = 19;
  localparam int DRV_W = DATA_W + 2;

  // Reciprocal constants: floor(n / 1000) = (n * M) >> 38 and floor(n / 10) = (n * M) >> 35
  // for every unsigned 32-bit n.
  localparam logic [DATA_W-1:0] DIV1000_MUL = 32'd274877907;
  localparam int                DIV1000_SH  = 38;
  localparam logic [DATA_W-1:0] DIV10_MUL   = 32'hCCCCCCCD;
  localparam int                DIV10_SH    = 35;

  // Saturation bounds of the integrator, in the accumulator width.
  localparam logic signed [IACC_W-1:0] INT_MAX_X =
    IACC_W'((65'sd1 <<< (INTEGRAL_WIDTH - 1)) - 65'sd1);
  localparam logic signed [IACC_W-1:0] INT_MIN_X = -INT_MAX_X - IACC_W'(1);

  localparam logic signed [DRV_W-1:0] DRV_MAX = 34'sd2147483647;
  localparam logic signed [DRV_W-1:0] DRV_MIN = -34'sd2147483648;

  // Configuration register reset values.
  localparam logic [31:0] RST_GAIN_P     = 32'd393;
  localparam logic [31:0] RST_GAIN_I     = 32'd328;
  localparam logic [31:0] RST_GAIN_D     = 32'd0;
  localparam logic [16:0] RST_LEAK       = 17'd39322;
  localparam logic [30:0] RST_ERR_LIM    = 31'd655360;
  localparam logic [30:0] RST_CORR_LIM   = 31'd655;
  localparam logic [31:0] RST_OFFSET     = 32'd393216;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P           = 3'd0,
    CFG_GAIN_I           = 3'd1,
    CFG_GAIN_D           = 3'd2,
    CFG_INTEGRAL_LEAK    = 3'd3,
    CFG_ERROR_LIMIT      = 3'd4,
    CFG_CORRECTION_LIMIT = 3'd5,
    CFG_DRIVE_OFFSET     = 3'd6
  } cfg_idx_t;

  // How a product is scaled before it reaches an accumulator.
  typedef enum logic [2:0] {
    SH_DIV1000,
    SH_DIV10,
    SH_LEAK_LO,
    SH_LEAK_HI,
    SH_FRAC_LO,
    SH_FRAC_HI
  } shift_t;

  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
    shift_t                  sh;
  } mul_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DSET,
    ST_DMEAS,
    ST_DTEN,
    ST_ERR,
    ST_LEAK_HI,
    ST_LEAK_SUM,
    ST_INTEG,
    ST_KD,
    ST_KI_LO,
    ST_KI_HI,
    ST_CLAMP,
    ST_DRIVE
  } state_t;

endpackage

// ===== design/leaky_integral_pid_with_clamps.sv =====
// Top level of the leaky-integral PID flow controller with error and correction clamps.
//
// Each item carries a setpoint and a measured flow in signed Q16.16. Both are divided by 1000
// (rounding toward zero), the error is their difference clamped to plus or minus error_limit,
// the integrator decays by integral_leak (values above 1.0 act as 1.0) and then adds the error,
// saturating at INTEGRAL_WIDTH signed bits. The correction Kp*err + Ki*integral +
// Kd*(err - previous err) is clamped to plus or minus correction_limit, and the drive is the
// correction plus drive_offset plus one tenth of the scaled setpoint, saturated to 32 bits.
// After acceptance, an item runs through nine issues of the single shared 33 x 33 multiplier
// (two divisions by 1000, one by 10, two leak partial products and four gain partial
// products), the final accumulate, the correction clamp and the drive step, before the block
// is ready again. The multiplier is the only arithmetic unit of weight, and its product
// register sits between each multiplication and the accumulator it feeds.
// The result sits in an output register, so the next item runs while a finished one waits;
// the drive step holds only if the previous result has still not been taken. Configuration
// writes are always ready and should be made while no item is in flight.
module leaky_integral_pid_with_clamps
  import lipc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    in_setpoint,
  input  logic signed [31:0]    in_measured,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    out_drive,
  output logic signed [31:0]    out_clamped_error,
  output logic                  out_correction_saturated,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_data
);

  // Configuration registers.
  logic signed [31:0] gain_p_r;
  logic signed [31:0] gain_i_r;
  logic signed [31:0] gain_d_r;
  logic [LEAK_W-1:0]  leak_r;
  logic [30:0]        err_lim_r;
  logic [30:0]        corr_lim_r;
  logic signed [31:0] offset_r;

  // Sequencer and controller state.
  state_t                           state_r;
  state_t                           state_nxt;
  logic signed [INTEGRAL_WIDTH-1:0] integral_r;
  logic signed [ERR_W-1:0]          prev_err_r;

  // Per-item working registers.
  logic signed [31:0]       set_r;
  logic signed [31:0]       meas_r;
  logic signed [SCL_W-1:0]  set_s_r;
  logic signed [SCL_W-1:0]  meas_s_r;
  logic signed [TEN_W-1:0]  tenth_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [IACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0]  corr_r;
  logic signed [31:0]       corr_c_r;
  logic                     hit_r;

  // Output register.
  logic               out_valid_r;
  logic signed [31:0] out_drive_r;
  logic signed [31:0] out_err_r;
  logic               out_hit_r;

  // Datapath signals.
  mul_req_t                 mul_req;
  logic signed [ACC_W-1:0]  term;
  logic signed [63:0]       integ_ext;
  logic [LEAK_W-1:0]        leak_eff;
  logic signed [SCL_W-1:0]  set_s_abs;
  logic signed [ERR_W:0]    err_diff;
  logic signed [ERR_W-1:0]  raw_err;
  logic signed [31:0]       raw_err32;
  logic signed [31:0]       err_lim32;
  logic signed [ERR_W-1:0]  err_clamped;
  logic signed [IACC_W-1:0] integ_sum;
  logic signed [INTEGRAL_WIDTH-1:0] integ_sat;
  logic signed [ACC_W-1:0]  corr_lim_x;
  logic signed [DRV_W-1:0]  drive_sum;
  logic signed [31:0]       drive_sat;
  logic                     in_take;
  logic                     out_take;
  logic                     out_load;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign cfg_ready = 1'b1;

  // The integrator is split into a signed high word and an unsigned low word for the
  // 33-bit multiplier.
  assign integ_ext = 64'(integral_r);
  assign leak_eff  = (leak_r > LEAK_ONE) ? LEAK_ONE : leak_r;
  assign set_s_abs = set_s_r[SCL_W-1] ? -set_s_r : set_s_r;
  assign err_diff  = (ERR_W+1)'(err_r) - (ERR_W+1)'(prev_err_r);

  // Error clamp on the two scaled inputs.
  assign raw_err   = ERR_W'(set_s_r) - ERR_W'(meas_s_r);
  assign raw_err32 = 32'(raw_err);
  assign err_lim32 = $signed({1'b0, err_lim_r});
  always_comb begin
    if (raw_err32 > err_lim32) begin
      err_clamped = ERR_W'(err_lim32);
    end else if (raw_err32 < -err_lim32) begin
      err_clamped = ERR_W'(-err_lim32);
    end else begin
      err_clamped = raw_err;
    end
  end

  // Integrator saturation of leaked value plus error.
  assign integ_sum = acc_r + IACC_W'(err_r);
  always_comb begin
    if (integ_sum > INT_MAX_X) begin
      integ_sat = INT_MAX_X[INTEGRAL_WIDTH-1:0];
    end else if (integ_sum < INT_MIN_X) begin
      integ_sat = INT_MIN_X[INTEGRAL_WIDTH-1:0];
    end else begin
      integ_sat = integ_sum[INTEGRAL_WIDTH-1:0];
    end
  end

  assign corr_lim_x = $signed(ACC_W'({1'b0, corr_lim_r}));

  // Drive: clamped correction plus offset plus one tenth of the scaled setpoint.
  assign drive_sum = DRV_W'(corr_c_r) + DRV_W'(offset_r) + DRV_W'(tenth_r);
  always_comb begin
    if (drive_sum > DRV_MAX) begin
      drive_sat = DRV_MAX[31:0];
    end else if (drive_sum < DRV_MIN) begin
      drive_sat = DRV_MIN[31:0];
    end else begin
      drive_sat = drive_sum[31:0];
    end
  end

  lipc_mul_shift u_mul (
    .clk  (clk),
    .req  (mul_req),
    .term (term)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_take) state_nxt = ST_DSET;
      ST_DSET:     state_nxt = ST_DMEAS;
      ST_DMEAS:    state_nxt = ST_DTEN;
      ST_DTEN:     state_nxt = ST_ERR;
      ST_ERR:      state_nxt = ST_LEAK_HI;
      ST_LEAK_HI:  state_nxt = ST_LEAK_SUM;
      ST_LEAK_SUM: state_nxt = ST_INTEG;
      ST_INTEG:    state_nxt = ST_KD;
      ST_KD:       state_nxt = ST_KI_LO;
      ST_KI_LO:    state_nxt = ST_KI_HI;
      ST_KI_HI:    state_nxt = ST_CLAMP;
      ST_CLAMP:    state_nxt = ST_DRIVE;
      ST_DRIVE:    if (out_load) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: input stall, output load and the multiplier request of each step.
  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    out_load   = (state_r == ST_DRIVE) && (!out_valid_r || !out_stall);
    mul_req.a  = '0;
    mul_req.b  = '0;
    mul_req.sh = SH_FRAC_LO;
    case (state_r)
      ST_DSET: begin
        mul_req.a  = $signed({1'b0, mag32(set_r)});
        mul_req.b  = $signed({1'b0, DIV1000_MUL});
        mul_req.sh = SH_DIV1000;
      end
      ST_DMEAS: begin
        mul_req.a  = $signed({1'b0, mag32(meas_r)});
        mul_req.b  = $signed({1'b0, DIV1000_MUL});
        mul_req.sh = SH_DIV1000;
      end
      ST_DTEN: begin
        mul_req.a  = MUL_W'(set_s_abs);
        mul_req.b  = $signed({1'b0, DIV10_MUL});
        mul_req.sh = SH_DIV10;
      end
      ST_ERR: begin
        mul_req.a  = $signed({1'b0, integ_ext[31:0]});
        mul_req.b  = $signed({{(MUL_W-LEAK_W){1'b0}}, leak_eff});
        mul_req.sh = SH_LEAK_LO;
      end
      ST_LEAK_HI: begin
        mul_req.a  = MUL_W'($signed(integ_ext[63:32]));
        mul_req.b  = $signed({{(MUL_W-LEAK_W){1'b0}}, leak_eff});
        mul_req.sh = SH_LEAK_HI;
      end
      ST_LEAK_SUM: begin
        mul_req.a  = MUL_W'(err_r);
        mul_req.b  = MUL_W'(gain_p_r);
        mul_req.sh = SH_FRAC_LO;
      end
      ST_INTEG: begin
        mul_req.a  = MUL_W'(err_diff);
        mul_req.b  = MUL_W'(gain_d_r);
        mul_req.sh = SH_FRAC_LO;
      end
      ST_KD: begin
        mul_req.a  = $signed({1'b0, integ_ext[31:0]});
        mul_req.b  = MUL_W'(gain_i_r);
        mul_req.sh = SH_FRAC_LO;
      end
      ST_KI_LO: begin
        mul_req.a  = MUL_W'($signed(integ_ext[63:32]));
        mul_req.b  = MUL_W'(gain_i_r);
        mul_req.sh = SH_FRAC_HI;
      end
      default: begin
        mul_req.sh = SH_FRAC_LO;
      end
    endcase
  end

  // Control state, configuration and controller state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      integral_r  <= '0;
      prev_err_r  <= '0;
      gain_p_r    <= RST_GAIN_P;
      gain_i_r    <= RST_GAIN_I;
      gain_d_r    <= RST_GAIN_D;
      leak_r      <= RST_LEAK;
      err_lim_r   <= RST_ERR_LIM;
      corr_lim_r  <= RST_CORR_LIM;
      offset_r    <= RST_OFFSET;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_INTEG) begin
        integral_r <= integ_sat;
      end
      if (state_r == ST_CLAMP) begin
        prev_err_r <= err_r;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GAIN_P:           gain_p_r   <= cfg_data;
          CFG_GAIN_I:           gain_i_r   <= cfg_data;
          CFG_GAIN_D:           gain_d_r   <= cfg_data;
          CFG_INTEGRAL_LEAK:    leak_r     <= cfg_data[LEAK_W-1:0];
          CFG_ERROR_LIMIT:      err_lim_r  <= cfg_data[30:0];
          CFG_CORRECTION_LIMIT: corr_lim_r <= cfg_data[30:0];
          CFG_DRIVE_OFFSET:     offset_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Working registers. Each step consumes the product issued in the step before it.
  always_ff @(posedge clk) begin
    if (in_take) begin
      set_r  <= in_setpoint;
      meas_r <= in_measured;
    end
    case (state_r)
      ST_DMEAS: begin
        set_s_r <= set_r[31] ? -$signed(term[SCL_W-1:0]) : $signed(term[SCL_W-1:0]);
      end
      ST_DTEN: begin
        meas_s_r <= meas_r[31] ? -$signed(term[SCL_W-1:0]) : $signed(term[SCL_W-1:0]);
      end
      ST_ERR: begin
        tenth_r <= set_s_r[SCL_W-1] ? -$signed(term[TEN_W-1:0])
                                    : $signed(term[TEN_W-1:0]);
        err_r   <= err_clamped;
      end
      ST_LEAK_HI:  acc_r  <= term[IACC_W-1:0];
      ST_LEAK_SUM: acc_r  <= acc_r + term[IACC_W-1:0];
      ST_INTEG:    corr_r <= term;
      ST_KD:       corr_r <= corr_r + term;
      ST_KI_LO:    corr_r <= corr_r + term;
      ST_KI_HI:    corr_r <= corr_r + term;
      ST_CLAMP: begin
        if (corr_r > corr_lim_x) begin
          corr_c_r <= corr_lim_x[31:0];
          hit_r    <= 1'b1;
        end else if (corr_r < -corr_lim_x) begin
          corr_c_r <= 32'(-corr_lim_x);
          hit_r    <= 1'b1;
        end else begin
          corr_c_r <= corr_r[31:0];
          hit_r    <= 1'b0;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_drive_r <= drive_sat;
      out_err_r   <= 32'(err_r);
      out_hit_r   <= hit_r;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_drive                = out_drive_r;
  assign out_clamped_error        = out_err_r;
  assign out_correction_saturated = out_hit_r;

`ifndef SYNTHESIS
  // A result only appears out of the drive step.
  a_out_from_drive: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DRIVE)
    else $error("output became valid outside the drive step");

  // An accepted item always starts the division steps.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r == ST_DSET)
    else $error("accepted item did not start the sequence");

  // The clamped error stays within the error limit.
  a_err_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LEAK_HI |-> (32'(err_r) <= err_lim32 && 32'(err_r) >= -err_lim32))
    else $error("clamped error outside its limit");

  // The clamped correction stays within the correction limit.
  a_corr_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRIVE |->
      (ACC_W'(corr_c_r) <= corr_lim_x && ACC_W'(corr_c_r) >= -corr_lim_x))
    else $error("clamped correction outside its limit");
`endif

endmodule

// ===== design/lipc_mul_shift.sv =====
// Shared signed multiplier with a registered product and a scaling shifter on its output.
module lipc_mul_shift
  import lipc_pkg::*;
(
  input  logic                    clk,
  input  mul_req_t                req,
  output logic signed [ACC_W-1:0] term
);

  logic signed [PROD_W-1:0] prod_r;
  shift_t                   sh_r;
  logic signed [TERM_W-1:0] lo_ext;
  logic signed [TERM_W-1:0] hi_ext;
  logic signed [TERM_W-1:0] shifted;

  always_ff @(posedge clk) begin
    prod_r <= req.a * req.b;
    sh_r   <= req.sh;
  end

  // A high partial product carries a weight of 2^32 before the right shift.
  assign lo_ext = TERM_W'(prod_r);
  assign hi_ext = $signed({prod_r, {DATA_W{1'b0}}});

  always_comb begin
    case (sh_r)
      SH_DIV1000: shifted = lo_ext >>> DIV1000_SH;
      SH_DIV10:   shifted = lo_ext >>> DIV10_SH;
      SH_LEAK_LO: shifted = lo_ext >>> LEAK_BITS;
      SH_LEAK_HI: shifted = hi_ext >>> LEAK_BITS;
      SH_FRAC_LO: shifted = lo_ext >>> FRAC_BITS;
      SH_FRAC_HI: shifted = hi_ext >>> FRAC_BITS;
      default:    shifted = lo_ext;
    endcase
  end

  assign term = shifted[ACC_W-1:0];

endmodule

// ===== tb/pid_drive_checker.sv =====
// Checker for the leaky-integral PID controller: predicts every result and compares it.
module pid_drive_checker
  import lipc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic signed [31:0]   in_setpoint,
  input  logic signed [31:0]   in_measured,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic signed [31:0]   out_drive,
  input  logic signed [31:0]   out_clamped_error,
  input  logic                 out_correction_saturated,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   mismatch_count,
  output int                   results_owed
);

  localparam longint SCALE_DIV = 1000;
  localparam longint TENTH_DIV = 10;
  localparam longint INTEG_MAX = (64'sd1 <<< (INTEGRAL_WIDTH - 1)) - 64'sd1;
  localparam longint INTEG_MIN = -INTEG_MAX - 64'sd1;
  localparam longint DRIVE_MAX = 64'sd2147483647;
  localparam longint DRIVE_MIN = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] drive;
    logic signed [31:0] clamped_error;
    logic               saturated;
  } pid_result_t;

  pid_result_t owed_drives[$];
  pid_result_t want;
  int          errors = 0;

  // Shadow copies of the registers and of the loop state.
  logic signed [31:0] gain_p, gain_i, gain_d, drive_offset;
  logic [LEAK_W-1:0]  leak_factor;
  logic [30:0]        error_limit, correction_limit;
  longint             integral, last_error;

  // Works out the result of one item and advances the loop state.
  task automatic predict_drive(input logic signed [31:0] sp, input logic signed [31:0] ms);
    longint             set_q, meas_q, diff, err, err_lim, lk, leaked, sum;
    longint             p_term, d_term, corr, drv;
    logic signed [127:0] ki_wide, int_wide, ki_term, total, lim_wide;
    pid_result_t         r;
    set_q   = longint'(sp) / SCALE_DIV;
    meas_q  = longint'(ms) / SCALE_DIV;
    diff    = set_q - meas_q;
    err_lim = error_limit;
    if (diff > err_lim) err = err_lim;
    else if (diff < -err_lim) err = -err_lim;
    else err = diff;

    // A leak factor above 1.0 behaves as exactly 1.0.
    lk     = (leak_factor > LEAK_ONE) ? LEAK_ONE : leak_factor;
    leaked = (integral * lk) >>> LEAK_BITS;
    sum    = leaked + err;
    if (sum > INTEG_MAX) sum = INTEG_MAX;
    if (sum < INTEG_MIN) sum = INTEG_MIN;
    integral = sum;

    // The integral term can exceed 64 bits, so the sum is formed wide.
    p_term   = (longint'(gain_p) * err) >>> FRAC_BITS;
    d_term   = (longint'(gain_d) * (err - last_error)) >>> FRAC_BITS;
    ki_wide  = gain_i;
    int_wide = integral;
    ki_term  = (ki_wide * int_wide) >>> FRAC_BITS;
    total    = ki_term + p_term + d_term;
    lim_wide = correction_limit;
    r.saturated = 1'b1;
    if (total > lim_wide) corr = longint'(lim_wide);
    else if (total < -lim_wide) corr = -longint'(lim_wide);
    else begin
      corr = longint'(total);
      r.saturated = 1'b0;
    end

    drv = corr + longint'(drive_offset) + set_q / TENTH_DIV;
    if (drv > DRIVE_MAX) drv = DRIVE_MAX;
    if (drv < DRIVE_MIN) drv = DRIVE_MIN;

    last_error      = err;
    r.drive         = 32'(drv);
    r.clamped_error = 32'(err);
    owed_drives.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      gain_p           = RST_GAIN_P;
      gain_i           = RST_GAIN_I;
      gain_d           = RST_GAIN_D;
      leak_factor      = RST_LEAK;
      error_limit      = RST_ERR_LIM;
      correction_limit = RST_CORR_LIM;
      drive_offset     = RST_OFFSET;
      integral         = 0;
      last_error       = 0;
      owed_drives.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GAIN_P:           gain_p = cfg_data;
          CFG_GAIN_I:           gain_i = cfg_data;
          CFG_GAIN_D:           gain_d = cfg_data;
          CFG_INTEGRAL_LEAK:    leak_factor = cfg_data[LEAK_W-1:0];
          CFG_ERROR_LIMIT:      error_limit = cfg_data[30:0];
          CFG_CORRECTION_LIMIT: correction_limit = cfg_data[30:0];
          CFG_DRIVE_OFFSET:     drive_offset = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (owed_drives.size() == 0) begin
          $error("unexpected result item: drive %0d, clamped_error %0d",
                 out_drive, out_clamped_error);
          errors++;
        end else begin
          want = owed_drives.pop_front();
          if (out_drive !== want.drive) begin
            $error("drive mismatch: expected %0d, actual %0d", want.drive, out_drive);
            errors++;
          end
          if (out_clamped_error !== want.clamped_error) begin
            $error("clamped_error mismatch: expected %0d, actual %0d",
                   want.clamped_error, out_clamped_error);
            errors++;
          end
          if (out_correction_saturated !== want.saturated) begin
            $error("correction_saturated mismatch: expected %0b, actual %0b",
                   want.saturated, out_correction_saturated);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_drive(in_setpoint, in_measured);
      end
    end
    mismatch_count <= errors;
    results_owed   <= owed_drives.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the PID controller testbench: clock, reset, stimulus, result sink and verdict.
module tb_top
  import lipc_pkg::*;
();

  // Number of consecutive max-error items at a leak of 1.0; each one adds the largest
  // scaled error, so the integrator climbs steadily and the integral term grows large.
  localparam int SOAK_ITEMS      = 20;
  localparam int RANDOM_PHASES   = 10;
  localparam int PHASE_ITEMS     = 130;
  localparam int HOLD_OFF_CYCLES = 400;
  // Settling pause after the last result has been taken.
  localparam int SETTLE_CYCLES   = 20;
  localparam longint TIMEOUT_UNITS = 64'd20_000_000;

  // Register index that maps to no register; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic [31:0]        U31_MAX = 32'h7FFF_FFFF;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic signed [31:0]    in_setpoint;
  logic signed [31:0]    in_measured;
  logic                  out_valid;
  logic                  out_stall;
  logic signed [31:0]    out_drive;
  logic signed [31:0]    out_clamped_error;
  logic                  out_correction_saturated;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [31:0]           cfg_data;

  int failures;
  int owed;

  // Idling controls shared by the stimulus and the result sink.
  bit src_steady;
  bit sink_steady;
  bit hold_off_req;
  int sink_seg_left;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  leaky_integral_pid_with_clamps uut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_setpoint              (in_setpoint),
    .in_measured              (in_measured),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_drive                (out_drive),
    .out_clamped_error        (out_clamped_error),
    .out_correction_saturated (out_correction_saturated),
    .cfg_valid                (cfg_valid),
    .cfg_ready                (cfg_ready),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data)
  );

  pid_drive_checker drive_check (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_setpoint              (in_setpoint),
    .in_measured              (in_measured),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_drive                (out_drive),
    .out_clamped_error        (out_clamped_error),
    .out_correction_saturated (out_correction_saturated),
    .cfg_valid                (cfg_valid),
    .cfg_ready                (cfg_ready),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data),
    .mismatch_count           (failures),
    .results_owed             (owed)
  );

  // Idle length for either side: usually none, often a few cycles, now and then a long gap.
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One of the values where the division by 1000 and the clamps are most sensitive.
  function automatic logic signed [31:0] corner_value();
    case ($urandom_range(0, 5))
      0:       return S32_MAX;
      1:       return S32_MIN;
      2:       return 32'sd0;
      3:       return 32'sd999;
      4:       return -32'sd999;
      default: return -32'sd1000;
    endcase
  endfunction

  // Builds one item. The largest share looks like a running loop, where the measurement sits
  // near or at the setpoint; the rest are full-range noise, small values and corner values.
  task automatic make_flow(output logic signed [31:0] sp, output logic signed [31:0] ms);
    int mode;
    int base;
    int noise;
    mode = $urandom_range(0, 9);
    if (mode <= 1) begin
      sp = $urandom;
      ms = $urandom;
    end else if (mode <= 5) begin
      base  = int'($urandom) >>> 1;
      noise = int'($urandom_range(0, 4000000)) - 2000000;
      sp    = base;
      ms    = base + noise;
    end else if (mode <= 7) begin
      sp = int'($urandom_range(0, 8388608)) - 4194304;
      ms = int'($urandom_range(0, 8388608)) - 4194304;
    end else if (mode == 8) begin
      sp = corner_value();
      ms = corner_value();
    end else begin
      sp = $urandom;
      ms = sp;
    end
  endtask

  // Offers one item on the input channel and returns at the edge where it is taken.
  // Valid is only lowered when a gap is inserted, so back-to-back items keep it high.
  task automatic offer_item(input logic signed [31:0] sp, input logic signed [31:0] ms);
    int gap;
    gap = src_steady ? 0 : pick_idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_setpoint <= sp;
    in_measured <= ms;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic offer_random_item();
    logic signed [31:0] sp;
    logic signed [31:0] ms;
    make_flow(sp, ms);
    offer_item(sp, ms);
  endtask

  // Withdraws the input and waits until every expected result has been taken, then lets
  // the block settle so that a register write cannot overlap an item.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(input logic [31:0] kp, input logic [31:0] ki,
                                input logic [31:0] kd, input logic [31:0] leak,
                                input logic [31:0] elim, input logic [31:0] clim,
                                input logic [31:0] offset);
    write_reg(CFG_GAIN_P, kp);
    write_reg(CFG_GAIN_I, ki);
    write_reg(CFG_GAIN_D, kd);
    write_reg(CFG_INTEGRAL_LEAK, leak);
    write_reg(CFG_ERROR_LIMIT, elim);
    write_reg(CFG_CORRECTION_LIMIT, clim);
    write_reg(CFG_DRIVE_OFFSET, offset);
  endtask

  // A random register set. Wild settings use raw 32-bit words for all but the leak, so the
  // unused top bits of the limit registers get exercised too; moderate ones keep the loop in
  // a range where the correction is usually not clamped.
  task automatic pick_settings(input bit wild);
    logic [31:0] kp, ki, kd, leak, elim, clim, offset;
    case ($urandom_range(0, 3))
      0:       leak = $urandom_range(0, 131071);
      1:       leak = $urandom_range(55000, 65536);
      2:       leak = LEAK_ONE;
      default: leak = $urandom_range(60000, 65535);
    endcase
    if (wild) begin
      kp     = $urandom;
      ki     = $urandom;
      kd     = $urandom;
      elim   = $urandom;
      clim   = $urandom;
      offset = $urandom;
    end else begin
      kp     = $urandom_range(0, 524288) - 262144;
      ki     = $urandom_range(0, 16384) - 8192;
      kd     = $urandom_range(0, 131072) - 65536;
      elim   = $urandom_range(0, 2000000);
      clim   = $urandom_range(0, 16777216);
      offset = $urandom_range(0, 2000000) - 1000000;
    end
    apply_settings(kp, ki, kd, leak, elim, clim, offset);
  endtask

  // Result sink. It stalls in random stretches, and on request from the stimulus it holds
  // off for one long fixed stretch so that the block backs up into its input.
  initial begin
    out_stall     = 1'b0;
    sink_seg_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        out_stall     <= 1'b0;
        hold_off_req  = 1'b0;
        sink_seg_left = 0;
      end else if (sink_seg_left > 0) begin
        sink_seg_left--;
      end else if (sink_steady) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall     <= 1'b1;
        sink_seg_left = pick_idle_len();
      end else begin
        out_stall     <= 1'b0;
        sink_seg_left = $urandom_range(0, 12);
      end
    end
  end

  // Watchdog: a run that hangs anywhere ends here.
  initial begin
    #(TIMEOUT_UNITS);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    in_valid     = 1'b0;
    in_setpoint  = '0;
    in_measured  = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    rst_n        = 1'b0;
    src_steady   = 1'b0;
    sink_steady  = 1'b0;
    hold_off_req = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed items at the reset settings: zero, the input extremes, the rounding of the
    // division by 1000 toward zero on both sides, and the error clamp at and just above its
    // upper limit and just below its lower limit.
    offer_item(32'sd0, 32'sd0);
    offer_item(S32_MAX, S32_MIN);
    offer_item(S32_MIN, S32_MAX);
    offer_item(S32_MAX, S32_MAX);
    offer_item(S32_MIN, S32_MIN);
    offer_item(32'sd999, -32'sd999);
    offer_item(-32'sd1000, 32'sd1000);
    offer_item(-32'sd1999, 32'sd2001);
    offer_item(32'sd655360000, 32'sd0);
    offer_item(32'sd655361000, 32'sd0);
    offer_item(-32'sd655361000, 32'sd0);
    drain();

    // All registers at their largest values: the integral term is huge, the correction
    // clamps and the drive overflows upward.
    apply_settings(S32_MAX, S32_MAX, S32_MAX, LEAK_ONE, U31_MAX, U31_MAX, S32_MAX);
    offer_item(S32_MAX, S32_MIN);
    offer_item(S32_MIN, S32_MAX);
    offer_item(32'sd0, 32'sd0);
    drain();

    // All registers at their smallest values: zero limits and leak, most negative gains
    // and offset, so the drive overflows downward.
    apply_settings(S32_MIN, S32_MIN, S32_MIN, 32'd0, 32'd0, 32'd0, S32_MIN);
    offer_item(S32_MIN, 32'sd0);
    offer_item(S32_MAX, 32'sd0);
    offer_item(32'sd0, S32_MAX);
    drain();

    // Leak word with every bit set, which must act as a leak of exactly 1.0, and a write
    // to the unused register index, which must be ignored.
    apply_settings(RST_GAIN_P, RST_GAIN_I, RST_GAIN_D, 32'hFFFF_FFFF,
                   RST_ERR_LIM, RST_CORR_LIM, RST_OFFSET);
    write_reg(CFG_IDX_UNUSED, $urandom);
    offer_item(S32_MAX, S32_MIN);
    offer_item(S32_MAX, S32_MIN);
    offer_item(32'sd123456789, -32'sd98765432);
    drain();

    // Integrator build-up. A zero leak clears the integral, then a leak of 1.0 with the
    // largest possible error piles it up item after item. A unit integral gain, zero Kp, Kd
    // and offset leave the drive as the integral term plus a tenth of the scaled setpoint.
    apply_settings(32'd0, 32'd1, 32'd0, 32'd0, U31_MAX, U31_MAX, 32'd0);
    offer_item(32'sd0, 32'sd0);
    drain();
    write_reg(CFG_INTEGRAL_LEAK, LEAK_ONE);
    src_steady  = 1'b1;
    sink_steady = 1'b1;
    repeat (SOAK_ITEMS) offer_item(S32_MAX, S32_MIN);
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    drain();

    // Random gains on top of the built-up integral, then a zero leak to clear it again.
    pick_settings(1'b0);
    write_reg(CFG_INTEGRAL_LEAK, LEAK_ONE);
    repeat (20) offer_random_item();
    drain();
    pick_settings(1'b1);
    write_reg(CFG_INTEGRAL_LEAK, LEAK_ONE);
    repeat (20) offer_random_item();
    drain();
    write_reg(CFG_INTEGRAL_LEAK, 32'd0);
    repeat (3) offer_random_item();
    drain();

    // Random phases, each with fresh settings. One phase runs with no idling at all, and
    // in another the sink holds off for a long stretch while items keep coming.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      pick_settings(p % 3 == 2);
      src_steady  = (p == 1);
      sink_steady = (p == 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 4 && i == PHASE_ITEMS / 2) begin
          hold_off_req = 1'b1;
          src_steady   = 1'b1;
          repeat (16) offer_random_item();
          src_steady   = 1'b0;
        end
        offer_random_item();
      end
      src_steady  = 1'b0;
      sink_steady = 1'b0;
      drain();
    end

    if (failures == 0 && owed == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
